[sv/seqf_pkg.sv]
// Shared types and constants for the sequence gap linear fill block.
package seqf_pkg;

    localparam int NUM_W   = 16;
    localparam int VAL_W   = 16;
    localparam int GAP_W   = 6;
    localparam int MAX_GAP = 63;

    typedef struct packed {
        logic [NUM_W-1:0]        seq_number;
        logic signed [VAL_W-1:0] sample_value;
        logic                    end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0]        out_number;
        logic signed [VAL_W-1:0] out_value;
        logic                    gap_too_long;
        logic                    run_last;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W:0]   dividend;
        logic [GAP_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W:0]   quotient;
    } t_div_rsp;

endpackage

[sv/seqf_div.sv]
// Serial restoring divider: signed dividend by small unsigned divisor, truncating.
module seqf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  seqf_pkg::t_div_req i_req,
    output seqf_pkg::t_div_rsp o_rsp
);
    import seqf_pkg::*;

    localparam int CNT_W = $clog2(VAL_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VAL_W-1:0]   r_q;
    logic [GAP_W-1:0]   r_rem;
    logic [GAP_W-1:0]   r_div;
    logic               r_neg;
    logic [VAL_W:0]     w_mag;
    logic [GAP_W:0]     w_trial;
    logic               w_ge;
    logic [GAP_W:0]     w_rem_n;

    assign w_mag   = i_req.dividend[VAL_W] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_trial = {r_rem, r_q[VAL_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_rem_n = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= w_mag[VAL_W-1:0];
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_neg  <= i_req.dividend[VAL_W];
            end else if (r_busy) begin
                r_q   <= {r_q[VAL_W-2:0], w_ge};
                r_rem <= w_rem_n[GAP_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

[sv/sequence_gap_linear_fill.sv]
// Top level: holds the last measurement and fills gaps by linear interpolation.
// An item that is only held or dropped is taken without raising the input stall. A lone
// entry is emitted for a gap too long, a dropped final item or a first item ending the stream;
// a long gap followed by a final item emits the held entry, then the final item. A filled gap
// of G entries, plus the final item if it ends the stream: the slope comes from a single 16-step
// serial divider, then one entry leaves per cycle, unless the output stalls, through an adder
// that steps the value. Input stall is high from acceptance until the last result is registered.
module sequence_gap_linear_fill (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  seqf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output seqf_pkg::t_out_item o_out_data
);
    import seqf_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_FILL, S_HELD, S_NEW} t_state;

    t_state                  r_state;
    logic                    r_have;
    logic [NUM_W-1:0]        r_held_num;
    logic signed [VAL_W-1:0] r_held_val;
    logic [NUM_W-1:0]        r_new_num;
    logic signed [VAL_W-1:0] r_new_val;
    logic                    r_eos;
    logic                    r_long;
    logic                    r_tail;
    logic [GAP_W-1:0]        r_gap;
    logic [GAP_W-1:0]        r_cnt;
    logic signed [VAL_W:0]   r_step;
    logic signed [VAL_W:0]   r_acc;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    w_emit;
    logic                    w_load;
    logic                    w_above;
    logic                    w_long;
    logic [NUM_W-1:0]        w_diff;
    logic                    w_fill_end;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    assign w_emit     = !r_out_valid || !i_out_stall;
    assign w_load     = w_emit && (r_state inside {S_FILL, S_HELD, S_NEW});
    assign w_above    = i_in_data.seq_number > r_held_num;
    assign w_diff     = i_in_data.seq_number - r_held_num;
    assign w_long     = w_diff > NUM_W'(MAX_GAP);
    assign w_fill_end = r_cnt == (r_gap - 1'b1);

    assign w_div_req.start    = (r_state == S_IDLE) && i_in_valid && r_have && w_above
                                && !w_long;
    assign w_div_req.dividend = {i_in_data.sample_value[VAL_W-1], i_in_data.sample_value}
                                - {r_held_val[VAL_W-1], r_held_val};
    assign w_div_req.divisor  = w_diff[GAP_W-1:0];

    seqf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_held_num  <= '0;
            r_held_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_new_num <= i_in_data.seq_number;
                    r_new_val <= i_in_data.sample_value;
                    r_eos     <= i_in_data.end_of_stream;
                    if (!r_have) begin
                        if (i_in_data.end_of_stream) begin
                            r_state <= S_NEW;
                        end else begin
                            r_have     <= 1'b1;
                            r_held_num <= i_in_data.seq_number;
                            r_held_val <= i_in_data.sample_value;
                        end
                    end else if (!w_above) begin
                        if (i_in_data.end_of_stream) begin
                            r_long  <= 1'b0;
                            r_tail  <= 1'b0;
                            r_state <= S_HELD;
                        end
                    end else if (w_long) begin
                        r_long  <= 1'b1;
                        r_tail  <= i_in_data.end_of_stream;
                        r_state <= S_HELD;
                    end else begin
                        r_gap   <= w_diff[GAP_W-1:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (w_div_rsp.done) begin
                    r_step  <= w_div_rsp.quotient;
                    r_acc   <= {r_held_val[VAL_W-1], r_held_val};
                    r_cnt   <= '0;
                    r_state <= S_FILL;
                end
                S_FILL: if (w_emit) begin
                    r_out_data.out_number   <= r_held_num + NUM_W'(r_cnt);
                    r_out_data.out_value    <= r_acc[VAL_W-1:0];
                    r_out_data.gap_too_long <= 1'b0;
                    r_out_data.run_last     <= w_fill_end && !r_eos;
                    r_acc                   <= r_acc + r_step;
                    r_cnt                   <= r_cnt + 1'b1;
                    if (w_fill_end) begin
                        if (r_eos) begin
                            r_state <= S_NEW;
                        end else begin
                            r_held_num <= r_new_num;
                            r_held_val <= r_new_val;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_HELD: if (w_emit) begin
                    r_out_data.out_number   <= r_held_num;
                    r_out_data.out_value    <= r_held_val;
                    r_out_data.gap_too_long <= r_long;
                    r_out_data.run_last     <= !r_tail;
                    if (r_tail) begin
                        r_state <= S_NEW;
                    end else if (r_long) begin
                        r_held_num <= r_new_num;
                        r_held_val <= r_new_val;
                        r_state    <= S_IDLE;
                    end else begin
                        r_have     <= 1'b0;
                        r_held_num <= '0;
                        r_held_val <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_NEW: if (w_emit) begin
                    r_out_data.out_number   <= r_new_num;
                    r_out_data.out_value    <= r_new_val;
                    r_out_data.gap_too_long <= 1'b0;
                    r_out_data.run_last     <= 1'b1;
                    r_have                  <= 1'b0;
                    r_held_num              <= '0;
                    r_held_val              <= '0;
                    r_state                 <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sv/seqf_chk.sv]
// Port-level checker for the sequence gap linear fill block, with its bind.
module seqf_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input seqf_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input seqf_pkg::t_out_item o_out_data
);
    import seqf_pkg::*;

    // results held back by the consumer stay put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output request changed while stalled");

    // stalled input request stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input request changed while stalled");

    // more results of the same request pending: no new request may be taken
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.run_last |-> o_in_stall)
        else $error("input taken before the run of results ended");

    // a flagged long gap that is not the last result still has its final item to come
    a_long_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.gap_too_long && !o_out_data.run_last |-> o_in_stall)
        else $error("flagged entry without its final item pending");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the outputs");

endmodule

bind sequence_gap_linear_fill seqf_chk u_seqf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/testbench.sv]
// Testbench for sequence_gap_linear_fill: queued driver, checking monitor, gap fill predictor.
`timescale 1ns / 1ps

module testbench;
    import seqf_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 208;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        t_in_item   item;
        logic [1:0] phase;
        logic       wait_drain;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_pending  pending[$];
    t_pending  next_req;
    t_out_item fill_expected[$];
    t_out_item want;
    logic [1:0] cur_phase = 2'd0;
    int        send_idle_pct[3] = '{20, 79, 0};
    int        recv_idle_pct[3] = '{79, 20, 0};
    int        mismatches = 0;
    int        cycle_count = 0;

    logic              held_valid = 1'b0;
    logic [NUM_W-1:0]  held_num = '0;
    logic signed [VAL_W-1:0] held_val = '0;

    sequence_gap_linear_fill uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_out_item make_entry(input logic [NUM_W-1:0] num, input int val,
                                             input logic flag);
        t_out_item r;
        r.out_number   = num;
        r.out_value    = val[VAL_W-1:0];
        r.gap_too_long = flag;
        r.run_last     = 1'b0;
        return r;
    endfunction

    task automatic fill_predict(input t_in_item req);
        t_out_item batch[$];
        t_out_item r;
        int a;
        int b;
        int gap;
        int slope;
        int k;
        b = req.sample_value;
        a = held_val;
        if (!held_valid) begin
            if (req.end_of_stream) begin
                batch = {batch, make_entry(req.seq_number, b, 1'b0)};
            end else begin
                held_valid = 1'b1;
                held_num   = req.seq_number;
                held_val   = req.sample_value;
            end
        end else if (req.seq_number <= held_num) begin
            if (req.end_of_stream) begin
                batch = {batch, make_entry(held_num, a, 1'b0)};
                held_valid = 1'b0;
                held_num   = '0;
                held_val   = '0;
            end
        end else begin
            gap = int'(req.seq_number) - int'(held_num);
            if (gap > MAX_GAP) begin
                batch = {batch, make_entry(held_num, a, 1'b1)};
            end else begin
                slope = (b - a) / gap;
                for (k = 0; k < gap; k++)
                    batch = {batch, make_entry(held_num + k[NUM_W-1:0], a + slope * k, 1'b0)};
            end
            if (req.end_of_stream) begin
                batch = {batch, make_entry(req.seq_number, b, 1'b0)};
                held_valid = 1'b0;
                held_num   = '0;
                held_val   = '0;
            end else begin
                held_num = req.seq_number;
                held_val = req.sample_value;
            end
        end
        for (k = 0; k < batch.size(); k++) begin
            r = batch[k];
            r.run_last = (k == batch.size() - 1);
            fill_expected = {fill_expected, r};
        end
    endtask

    task automatic add_item(input logic [NUM_W-1:0] num, input logic [VAL_W-1:0] val,
                            input logic eos, input logic [1:0] phase, input logic drain);
        t_pending p;
        p.item.seq_number    = num;
        p.item.sample_value  = val;
        p.item.end_of_stream = eos;
        p.phase              = phase;
        p.wait_drain         = drain;
        pending = {pending, p};
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'h8000;
        if (r < 10)
            return 16'h7FFF;
        return VAL_W'($urandom_range(0, 65535));
    endfunction

    // driver: new request only when the line is free; stalled payload holds
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (pending.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct[pending[0].phase]
                    && (!pending[0].wait_drain || (!in_valid && fill_expected.size() == 0))) begin
                next_req = pending.pop_front();
                in_data   <= next_req.item;
                in_valid  <= 1'b1;
                cur_phase <= next_req.phase;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct[cur_phase]);
    end

    // monitor: predict on accepted request, then check accepted result
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                fill_predict(in_data);
            if (o_out_valid && !out_stall) begin
                if (fill_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("unexpected result: num %0d val %0d gap %0b last %0b",
                                 o_out_data.out_number, o_out_data.out_value,
                                 o_out_data.gap_too_long, o_out_data.run_last);
                end else begin
                    want = fill_expected.pop_front();
                    if (o_out_data !== want) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                            $display("mismatch: exp num %0d val %0d gap %0b last %0b,",
                                     want.out_number, want.out_value, want.gap_too_long,
                                     want.run_last,
                                     " got num %0d val %0d gap %0b last %0b",
                                     o_out_data.out_number, o_out_data.out_value,
                                     o_out_data.gap_too_long, o_out_data.run_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : stimulus
        int counted;
        int len;
        int k;
        int r;
        int gap;
        int num;
        logic [1:0] phase;
        logic [1:0] last_phase;

        // directed: first item, extremes, drops, long gaps, max fill, truncation
        add_item(16'd5, 16'd100, 1'b1, 2'd0, 1'b0);
        add_item(16'd10, 16'h8000, 1'b0, 2'd0, 1'b0);
        add_item(16'd11, 16'h7FFF, 1'b0, 2'd0, 1'b0);
        add_item(16'd14, 16'h8000, 1'b0, 2'd0, 1'b0);
        add_item(16'd14, 16'd5, 1'b0, 2'd0, 1'b0);
        add_item(16'd3, 16'd0, 1'b0, 2'd0, 1'b0);
        add_item(16'd2, 16'd7, 1'b1, 2'd0, 1'b0);
        add_item(16'd0, 16'd0, 1'b0, 2'd0, 1'b0);
        add_item(16'd63, 16'h7FFF, 1'b0, 2'd0, 1'b0);
        add_item(16'd127, 16'hFFFF, 1'b0, 2'd0, 1'b0);
        add_item(16'hFFFF, 16'h8000, 1'b1, 2'd0, 1'b0);
        add_item(16'hFFFF, 16'd1, 1'b0, 2'd0, 1'b0);
        add_item(16'hFFFF, 16'd2, 1'b0, 2'd0, 1'b0);
        add_item(16'd0, 16'd3, 1'b1, 2'd0, 1'b0);
        add_item(16'd100, 16'hFFFB, 1'b0, 2'd0, 1'b0);
        add_item(16'd107, 16'd9, 1'b1, 2'd0, 1'b0);
        add_item(16'd200, 16'd0, 1'b0, 2'd0, 1'b0);
        add_item(16'd203, 16'hFFF9, 1'b0, 2'd0, 1'b0);
        add_item(16'd205, 16'd8, 1'b0, 2'd0, 1'b0);
        add_item(16'd268, 16'h8000, 1'b1, 2'd0, 1'b0);
        add_item(16'd300, 16'h7FFF, 1'b0, 2'd0, 1'b1);
        add_item(16'd301, 16'h8000, 1'b1, 2'd0, 1'b0);

        // random: mostly rising streams ending in end_of_stream, some noise
        counted = 0;
        last_phase = 2'd0;
        while (counted < RANDOM_ITEMS) begin
            phase = (counted < RANDOM_ITEMS / 3) ? 2'd0 :
                    (counted < 2 * RANDOM_ITEMS / 3) ? 2'd1 : 2'd2;
            if ($urandom_range(0, 9) == 0) begin
                add_item(NUM_W'($urandom_range(0, 65535)), pick_value(),
                         $urandom_range(0, 3) == 0, phase, 1'b0);
                counted++;
            end else begin
                len = $urandom_range(1, 8);
                num = $urandom_range(0, 65535);
                for (k = 0; k < len; k++) begin
                    add_item(num[NUM_W-1:0], pick_value(), k == len - 1, phase,
                             k == 0 && (phase != last_phase || $urandom_range(0, 29) == 0));
                    counted++;
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        gap = $urandom_range(1, 6);
                    else if (r < 80)
                        gap = $urandom_range(7, MAX_GAP);
                    else if (r < 88)
                        gap = $urandom_range(MAX_GAP + 1, 300);
                    else if (r < 94)
                        gap = $urandom_range(MAX_GAP, MAX_GAP + 1);
                    else
                        gap = -$urandom_range(0, 3);
                    num = num + gap;
                end
                last_phase = phase;
            end
        end

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || fill_expected.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatches == 0 && fill_expected.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
